@@ rtl/fbbf_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbbf_pkg
// Shared types and constants for the free bin bitmap finder.
// ----------------------------------------------------------------------------
package fbbf_pkg;

	localparam int OP_W   = 3;
	localparam int SIZE_W = 32;
	localparam int BIN_W  = 6;

	localparam int NUM_BINS_DEF     = 64;
	localparam int GRANULE_LOG2_DEF = 5;

	typedef enum logic [OP_W-1:0] {
		OP_FIND  = 3'd0,
		OP_SET   = 3'd1,
		OP_CLEAR = 3'd2,
		OP_TEST  = 3'd3,
		OP_MAP   = 3'd4
	} op_t;

	typedef struct packed {
		logic             found;
		logic [BIN_W-1:0] bin;
	} find_res_t;

	typedef struct packed {
		logic             found;
		logic [BIN_W-1:0] bin_number;
		logic             bit_was_set;
	} result_t;

endpackage

@@ rtl/fbbf_size_bin.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbbf_size_bin
// Byte size to bin number: ceil(size / granule) - 1, zero size gives bin 0,
// clamped to the top bin.
// ----------------------------------------------------------------------------
module fbbf_size_bin #(
	parameter int NUM_BINS     = fbbf_pkg::NUM_BINS_DEF,
	parameter int GRANULE_LOG2 = fbbf_pkg::GRANULE_LOG2_DEF
) (
	input  logic [fbbf_pkg::SIZE_W-1:0] size,
	output logic [fbbf_pkg::BIN_W-1:0]  bin
);

	localparam logic [fbbf_pkg::SIZE_W-1:0] TOP_BIN = fbbf_pkg::SIZE_W'(NUM_BINS - 1);

	logic [fbbf_pkg::SIZE_W-1:0] size_m1;
	logic [fbbf_pkg::SIZE_W-1:0] raw;

	always_comb begin
		size_m1 = size - fbbf_pkg::SIZE_W'(1);
		raw     = size_m1 >> GRANULE_LOG2;
		if (size == '0) begin
			bin = '0;
		end else if (raw > TOP_BIN) begin
			bin = TOP_BIN[fbbf_pkg::BIN_W-1:0];
		end else begin
			bin = raw[fbbf_pkg::BIN_W-1:0];
		end
	end

endmodule

@@ rtl/fbbf_find.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbbf_find
// Masks off bins below the needed one and priority-encodes the lowest
// populated bin that remains.
// ----------------------------------------------------------------------------
module fbbf_find #(
	parameter int NUM_BINS = fbbf_pkg::NUM_BINS_DEF
) (
	input  logic [NUM_BINS-1:0]        bitmap,
	input  logic [fbbf_pkg::BIN_W-1:0] need,
	input  logic                       size_ok,
	output fbbf_pkg::find_res_t        res
);

	logic [NUM_BINS-1:0] hits;

	always_comb begin
		hits      = bitmap & ({NUM_BINS{1'b1}} << need);
		res.found = size_ok && (hits != '0);
		res.bin   = '0;
		for (int i = NUM_BINS - 1; i >= 0; i--) begin
			if (hits[i]) begin
				res.bin = fbbf_pkg::BIN_W'(i);
			end
		end
		if (!res.found) begin
			res.bin = '0;
		end
	end

endmodule

@@ rtl/free_bin_bitmap_finder.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// free_bin_bitmap_finder
// Occupancy map of a segregated free list with find, set, clear, test, map.
// ----------------------------------------------------------------------------
// Requests enter on req_valid/req_ready with opcode, request_size and
// bin_index; each gives exactly one result on res_valid/res_ready carrying
// found, bin_number and bit_was_set, in request order.
// Result valid rises once an accepted request has passed through both
// registers: the request is held in the input register, then the find mask,
// priority encoder and bitmap update run in one pass as it moves into the
// result register.
// Throughput is one request per cycle while the receiver keeps res_ready
// high; the bitmap is read and written at that single hand-over point, so
// back-to-back set/find pairs see each other in order.
// When the receiver stalls, the result register holds and the input
// register fills; req_ready then drops until the result is taken.
// Reset clears the bitmap (no bin populated) and empties both registers.
// Unused opcodes and set/clear return an all-zero result.
// ----------------------------------------------------------------------------
module free_bin_bitmap_finder #(
	parameter int NUM_BINS     = fbbf_pkg::NUM_BINS_DEF,
	parameter int GRANULE_LOG2 = fbbf_pkg::GRANULE_LOG2_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        req_valid,
	output logic                        req_ready,
	input  logic [fbbf_pkg::OP_W-1:0]   opcode,
	input  logic [fbbf_pkg::SIZE_W-1:0] request_size,
	input  logic [fbbf_pkg::BIN_W-1:0]  bin_index,
	output logic                        res_valid,
	input  logic                        res_ready,
	output logic                        found,
	output logic [fbbf_pkg::BIN_W-1:0]  bin_number,
	output logic                        bit_was_set
);

	localparam logic [fbbf_pkg::SIZE_W-1:0] MAX_FIND =
		fbbf_pkg::SIZE_W'(NUM_BINS) << GRANULE_LOG2;

	logic                        valid_s1;
	logic [fbbf_pkg::OP_W-1:0]   opcode_s1;
	logic [fbbf_pkg::SIZE_W-1:0] size_s1;
	logic [fbbf_pkg::BIN_W-1:0]  index_s1;

	logic                        valid_s2;
	fbbf_pkg::result_t           res_s2;

	logic [NUM_BINS-1:0]         bitmap_q;
	logic [NUM_BINS-1:0]         bitmap_d;

	logic                        advance;
	logic                        idx_ok;
	logic [fbbf_pkg::BIN_W-1:0]  size_bin;
	fbbf_pkg::find_res_t         find_res;
	fbbf_pkg::result_t           res_d;

	assign advance   = valid_s1 && (!valid_s2 || res_ready);
	assign req_ready = !valid_s1 || advance;
	assign idx_ok    = {1'b0, index_s1} < (fbbf_pkg::BIN_W + 1)'(NUM_BINS);

	fbbf_size_bin #(
		.NUM_BINS     (NUM_BINS),
		.GRANULE_LOG2 (GRANULE_LOG2)
	) u_size_bin (
		.size (size_s1),
		.bin  (size_bin)
	);

	fbbf_find #(
		.NUM_BINS (NUM_BINS)
	) u_find (
		.bitmap  (bitmap_q),
		.need    (size_bin),
		.size_ok (size_s1 <= MAX_FIND),
		.res     (find_res)
	);

	always_comb begin
		res_d    = '0;
		bitmap_d = bitmap_q;
		unique case (opcode_s1)
			fbbf_pkg::OP_FIND: begin
				res_d.found      = find_res.found;
				res_d.bin_number = find_res.bin;
			end
			fbbf_pkg::OP_SET: begin
				if (idx_ok) begin
					bitmap_d[index_s1[$clog2(NUM_BINS)-1:0]] = 1'b1;
				end
			end
			fbbf_pkg::OP_CLEAR: begin
				if (idx_ok) begin
					bitmap_d[index_s1[$clog2(NUM_BINS)-1:0]] = 1'b0;
				end
			end
			fbbf_pkg::OP_TEST: begin
				if (idx_ok) begin
					res_d.bit_was_set = bitmap_q[index_s1[$clog2(NUM_BINS)-1:0]];
				end
			end
			fbbf_pkg::OP_MAP: begin
				res_d.bin_number = size_bin;
			end
			default: begin
				res_d = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			bitmap_q <= '0;
		end else begin
			if (req_ready) begin
				valid_s1 <= req_valid;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
				bitmap_q <= bitmap_d;
			end else if (res_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_ready && req_valid) begin
			opcode_s1 <= opcode;
			size_s1   <= request_size;
			index_s1  <= bin_index;
		end
		if (advance) begin
			res_s2 <= res_d;
		end
	end

	assign res_valid   = valid_s2;
	assign found       = res_s2.found;
	assign bin_number  = res_s2.bin_number;
	assign bit_was_set = res_s2.bit_was_set;

endmodule
